/* rtl/core/adlr_pkg.sv */
// Package for the audio delay line realign core.
// Holds the word types, operation and mode codes, and default sizes.
// No dependencies.
`default_nettype none

package adlr_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int DELAY_W      = 12;
    localparam int FUNC_W       = 2;
    localparam int MODE_W       = 2;
    localparam int DEPTH_DEF    = 4096;
    localparam int MARGIN_DEF   = 10;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_DELAY = 2'd2
    } t_func;

    // Alignment modes: which side is held while the pointers realign.
    typedef enum logic [MODE_W-1:0] {
        MODE_ALIGNED = 2'd0,
        MODE_RD_HOLD = 2'd1,
        MODE_WR_HOLD = 2'd2
    } t_mode;

    // Sweep state of the store clearing after reset.
    typedef enum logic {
        CLR_SWEEP = 1'b0,
        CLR_DONE  = 1'b1
    } t_clr_state;

    // One input word.
    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [DELAY_W-1:0]         new_delay;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic                       served;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       accepted;
        logic [MODE_W-1:0]          mode_now;
    } t_out_word;

    // Result status that travels with an item while the store read completes.
    typedef struct packed {
        logic              rd_served;
        logic              served;
        logic              accepted;
        logic [MODE_W-1:0] mode_now;
    } t_meta;

endpackage

`default_nettype wire

/* rtl/core/adlr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module adlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adlr_ctrl.sv */
// Pointer, delay and mode control for the delay line, plus the store clearing sweep.
// Depends on adlr_pkg; drives the ports of one adlr_ram.
`default_nettype none

module adlr_ctrl #(
    parameter int DEPTH  = adlr_pkg::DEPTH_DEF,
    parameter int MARGIN = adlr_pkg::MARGIN_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire adlr_pkg::t_in_word              i_word,
    input  wire logic                            i_adv,
    output logic                                 o_fire,
    output adlr_pkg::t_meta                      o_meta,
    output logic                                 o_we,
    output logic [$clog2(DEPTH)-1:0]             o_waddr,
    output logic [adlr_pkg::SAMPLE_W-1:0]        o_wdata,
    output logic                                 o_re,
    output logic [$clog2(DEPTH)-1:0]             o_raddr
);
    import adlr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    // Compare width: holds DEPTH itself and any delay value.
    localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] LIMIT_C = CW'(DEPTH - MARGIN);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_clr_state r_state, n_state;
    logic [AW-1:0] r_clr_idx, n_clr_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    t_mode r_mode, n_mode;
    logic [DELAY_W-1:0] r_delay, n_delay;

    logic clearing;
    logic wr_serve;
    logic rd_serve;
    logic accepted;
    logic [CW-1:0] wr_ext;
    logic [CW-1:0] rd_ext;
    logic [CW-1:0] ptr_dist;
    logic [CW-1:0] dly_ext;
    logic [CW-1:0] req_ext;

    // Sweep sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CLR_SWEEP: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = CLR_DONE;
                end
            end
            CLR_DONE: begin
                n_state = CLR_DONE;
            end
            default: begin
                n_state = CLR_SWEEP;
            end
        endcase
    end

    // Sweep sequencer: outputs.
    always_comb begin
        unique case (r_state)
            CLR_SWEEP: clearing = 1'b1;
            CLR_DONE:  clearing = 1'b0;
            default:   clearing = 1'b1;
        endcase
    end

    assign n_clr_idx = r_clr_idx + 1'b1;

    // Items enter only after the sweep and when the result stage can move.
    assign o_ready = !clearing && i_adv;
    assign o_fire  = i_valid && o_ready;

    // Pointer distance, write minus read modulo DEPTH.
    assign wr_ext   = CW'(r_wr_idx);
    assign rd_ext   = CW'(r_rd_idx);
    assign dly_ext  = CW'(r_delay);
    assign req_ext  = CW'(i_word.new_delay);
    assign ptr_dist = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (DEPTH_C - rd_ext + wr_ext);

    // Operation decode with the mode check ahead of each serviced access.
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_mode   = r_mode;
        n_delay  = r_delay;
        wr_serve = 1'b0;
        rd_serve = 1'b0;
        accepted = 1'b0;
        if (o_fire) begin
            unique case (i_word.func)
                FUNC_WRITE: begin
                    if (r_mode != MODE_WR_HOLD) begin
                        wr_serve = 1'b1;
                        if (r_mode == MODE_RD_HOLD) begin
                            if (ptr_dist == dly_ext) begin
                                n_mode = MODE_ALIGNED;
                            end else if (ptr_dist > dly_ext) begin
                                n_mode = MODE_WR_HOLD;
                            end
                        end
                        n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
                    end
                end
                FUNC_READ: begin
                    if (r_mode != MODE_RD_HOLD) begin
                        rd_serve = 1'b1;
                        if (r_mode == MODE_WR_HOLD) begin
                            if (ptr_dist == dly_ext) begin
                                n_mode = MODE_ALIGNED;
                            end else if (ptr_dist < dly_ext) begin
                                n_mode = MODE_RD_HOLD;
                            end
                        end
                        n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                    end
                end
                FUNC_DELAY: begin
                    if (req_ext < LIMIT_C) begin
                        accepted = 1'b1;
                        if (i_word.new_delay < r_delay) begin
                            n_mode = MODE_RD_HOLD;
                        end else if (i_word.new_delay > r_delay) begin
                            n_mode = MODE_WR_HOLD;
                        end
                        n_delay = i_word.new_delay;
                    end
                end
                default: begin
                    // Unused code: no state change.
                end
            endcase
        end
    end

    // Store port steering: the sweep writes zeros, otherwise served accesses.
    always_comb begin
        if (clearing) begin
            o_we    = 1'b1;
            o_waddr = r_clr_idx;
            o_wdata = '0;
        end else begin
            o_we    = wr_serve;
            o_waddr = r_wr_idx;
            o_wdata = i_word.sample_in;
        end
    end

    assign o_re    = rd_serve;
    assign o_raddr = r_rd_idx;

    // Status that follows the item to the result stage.
    always_comb begin
        o_meta.rd_served = rd_serve;
        o_meta.served    = wr_serve || rd_serve;
        o_meta.accepted  = accepted;
        o_meta.mode_now  = n_mode;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= CLR_SWEEP;
            r_clr_idx <= '0;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_mode    <= MODE_ALIGNED;
            r_delay   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_mode    <= n_mode;
            r_delay   <= n_delay;
        end
    end

    // The write pointer moves only on a served write.
    a_wr_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !wr_serve) |=> $stable(r_wr_idx))
        else $error("write index moved without a served write");

    // The read pointer moves only on a served read.
    a_rd_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !rd_serve) |=> $stable(r_rd_idx))
        else $error("read index moved without a served read");

    // A stored delay is always one that passed the limit check.
    a_delay_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dly_ext < LIMIT_C)
        else $error("delay register above the allowed limit");

endmodule

`default_nettype wire

/* rtl/core/audio_delay_line_realign_core.sv */
// Top level of the audio delay line realign core.
// Depends on adlr_pkg, adlr_ctrl and adlr_ram.
//
// Usage:
//   Input channel (i_in_valid, o_in_ready, i_in) carries one word per item:
//   func 0 writes a sample, func 1 reads the delayed sample, func 2 requests a
//   new delay. Output channel (o_out_valid, i_out_ready, o_out) returns one
//   word per item, in order.
//   Throughput: one item per cycle while the output is not stalled. Pointer, mode
//   and delay updates finish in the accept cycle; the store read is registered
//   beside the result stage, and the result word is valid from the output register.
//   Reset: i_rst_n is synchronous, active low. After reset the block sweeps all
//   DEPTH entries of the sample store (4096 at the default size) to zero, one
//   entry per cycle, with o_in_ready low.
//   Stall: a result stage and an output register sit between the channels, so
//   input keeps flowing while one result waits; when both are full,
//   o_in_ready drops in the same cycle that i_out_ready is low.
`default_nettype none

module audio_delay_line_realign_core #(
    parameter int DEPTH  = adlr_pkg::DEPTH_DEF,
    parameter int MARGIN = adlr_pkg::MARGIN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire adlr_pkg::t_in_word   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output adlr_pkg::t_out_word       o_out
);
    import adlr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                fire;
    logic                adv;
    logic                out_move;
    t_meta               meta;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic      r_s1_valid, n_s1_valid;
    t_meta     r_s1_meta;
    logic      r_o_valid, n_o_valid;
    t_out_word r_o_word, n_o_word;

    adlr_ctrl #(
        .DEPTH  (DEPTH),
        .MARGIN (MARGIN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in),
        .i_adv   (adv),
        .o_fire  (fire),
        .o_meta  (meta),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_re    (ram_re),
        .o_raddr (ram_raddr)
    );

    adlr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Flow control between the result stage and the output register.
    assign out_move = !r_o_valid || i_out_ready;
    assign adv      = !r_s1_valid || out_move;

    // Result stage: waits here while the store read completes.
    always_comb begin
        if (fire) begin
            n_s1_valid = 1'b1;
        end else if (out_move) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // Output register: word assembled from the status and the read data.
    always_comb begin
        n_o_valid = r_o_valid;
        n_o_word  = r_o_word;
        if (out_move) begin
            n_o_valid           = r_s1_valid;
            n_o_word.served     = r_s1_meta.served;
            n_o_word.sample_out = r_s1_meta.rd_served ? $signed(ram_rdata) : '0;
            n_o_word.accepted   = r_s1_meta.accepted;
            n_o_word.mode_now   = r_s1_meta.mode_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_meta <= meta;
        end
        r_o_word <= n_o_word;
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_o_word;

    // A word that was not a served access carries no sample.
    a_sample_only_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.served) |-> (o_out.sample_out == '0))
        else $error("sample on a word without a served access");

    // A delay acceptance and a served access never share one word.
    a_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.served && o_out.accepted))
        else $error("word marked both served and accepted");

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result word changed while stalled");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Regression bench for audio_delay_line_realign_core: directed and random words with a scoreboard.
// Depends on adlr_pkg and the audio_delay_line_realign_core RTL.

module tb;

    import adlr_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int MARGIN         = MARGIN_DEF;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int CALM_TAIL      = 200;
    localparam int SQUEEZE_AT     = 700;
    localparam int SQUEEZE_CYCLES = 320;
    localparam int QUIET_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 8;

    // The func code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Scoreboard: mirrors the delay line and holds the result words still due.
    class delay_line_board;
        logic [SAMPLE_W-1:0] store_words [DEPTH];
        int                  wr_idx;
        int                  rd_idx;
        int                  delay_now;
        t_mode               mode;
        t_out_word           pending_words [$];
        int                  errors;

        function new();
            for (int i = 0; i < DEPTH; i++) store_words[i] = '0;
            wr_idx    = 0;
            rd_idx    = 0;
            delay_now = 0;
            mode      = MODE_ALIGNED;
            errors    = 0;
        endfunction

        // Advance the mirror by one accepted word and queue the result it causes.
        function void note_input(t_in_word w);
            t_out_word want;
            int        ptr_gap;
            want    = '0;
            ptr_gap = (wr_idx - rd_idx + DEPTH) % DEPTH;
            case (w.func)
                FUNC_WRITE: begin
                    if (mode != MODE_WR_HOLD) begin
                        // The mode check runs first, then the write still goes ahead.
                        if (mode == MODE_RD_HOLD) begin
                            if (ptr_gap == delay_now) mode = MODE_ALIGNED;
                            else if (ptr_gap > delay_now) mode = MODE_WR_HOLD;
                        end
                        store_words[wr_idx] = w.sample_in;
                        wr_idx              = (wr_idx + 1) % DEPTH;
                        want.served         = 1'b1;
                    end
                end
                FUNC_READ: begin
                    if (mode != MODE_RD_HOLD) begin
                        if (mode == MODE_WR_HOLD) begin
                            if (ptr_gap == delay_now) mode = MODE_ALIGNED;
                            else if (ptr_gap < delay_now) mode = MODE_RD_HOLD;
                        end
                        want.sample_out = store_words[rd_idx];
                        rd_idx          = (rd_idx + 1) % DEPTH;
                        want.served     = 1'b1;
                    end
                end
                FUNC_DELAY: begin
                    // Requests at or above DEPTH-MARGIN are refused without any change.
                    if (int'(w.new_delay) < DEPTH - MARGIN) begin
                        if (int'(w.new_delay) < delay_now) mode = MODE_RD_HOLD;
                        else if (int'(w.new_delay) > delay_now) mode = MODE_WR_HOLD;
                        delay_now     = int'(w.new_delay);
                        want.accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            want.mode_now = mode;
            pending_words.push_back(want);
        endfunction

        // Compare one delivered result word with the oldest one due.
        function void check_result(t_out_word got);
            t_out_word want;
            if (pending_words.size() == 0) begin
                $error("result word with none due: served %0d sample_out %0d accepted %0d mode %0d",
                       got.served, got.sample_out, got.accepted, got.mode_now);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.served !== want.served) begin
                $error("served: expected %0d, actual %0d", want.served, got.served);
                errors++;
            end
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
                errors++;
            end
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.mode_now !== want.mode_now) begin
                $error("mode_now: expected %0d, actual %0d", want.mode_now, got.mode_now);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out;

    delay_line_board board = new();

    // Controls for the idling of both sides and the watchdog count.
    bit idle_on     = 1'b1;
    bit squeeze_req = 1'b0;
    int send_calm   = 0;
    int quiet_cycles = 0;

    audio_delay_line_realign_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    // Build one input word.
    function automatic t_in_word make_word(logic [FUNC_W-1:0] func, logic [SAMPLE_W-1:0] sample,
                                           logic [DELAY_W-1:0] delay_req);
        t_in_word w;
        w.func      = func;
        w.sample_in = sample;
        w.new_delay = delay_req;
        return w;
    endfunction

    // Random sample word, with the extremes showing up now and then.
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, hold it until it is taken, then maybe leave a gap.
    task automatic send_word(input t_in_word w);
        int gap;
        i_in       <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(w);
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else if (idle_on) begin
            case ($urandom_range(0, 39))
                0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 14);
                6:                send_calm = $urandom_range(20, 60);
                default:          ;
            endcase
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: checks each delivered word and stalls in random bursts.
    initial begin : receiver
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_result(o_out);
            if (squeeze_req) begin
                // Long hold-off so the block fills up and stalls its input.
                squeeze_req = 1'b0;
                stall_left  = SQUEEZE_CYCLES;
            end else if (stall_left == 0 && calm_left > 0) begin
                calm_left--;
            end else if (stall_left == 0 && idle_on) begin
                case ($urandom_range(0, 49))
                    0, 1, 2, 3, 4, 5, 6: stall_left = $urandom_range(1, 14);
                    7:                   calm_left  = $urandom_range(20, 60);
                    default:             ;
                endcase
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("audio_delay_line_realign_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed words, random segments, drain and verdict.
    initial begin : main_seq
        int n_items;
        int run_len;
        int pick;
        int delay_pick;
        bit squeeze_done;
        n_items      = 0;
        squeeze_done = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of the sample word, then a longer delay that holds writes.
        send_word(make_word(FUNC_WRITE, 32'h7fff_ffff, DELAY_W'($urandom)));
        send_word(make_word(FUNC_WRITE, 32'h8000_0000, DELAY_W'($urandom)));
        send_word(make_word(FUNC_WRITE, 32'h0000_0000, DELAY_W'($urandom)));
        send_word(make_word(FUNC_WRITE, 32'hffff_ffff, DELAY_W'($urandom)));
        send_word(make_word(FUNC_DELAY, $urandom, 12'd2));
        // Write held, then reads bring the distance down to the delay.
        send_word(make_word(FUNC_WRITE, 32'h0000_0005, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        // Shorter delay holds reads; the write that checks flips to the other side.
        send_word(make_word(FUNC_DELAY, $urandom, 12'd0));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_WRITE, 32'h1234_5678, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        // Reading past the write pointer returns a cleared entry.
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        // Largest legal delay, the first refused one, the top code and an equal request.
        send_word(make_word(FUNC_DELAY, $urandom, 12'(DEPTH - MARGIN - 1)));
        send_word(make_word(FUNC_DELAY, $urandom, 12'(DEPTH - MARGIN)));
        send_word(make_word(FUNC_DELAY, $urandom, 12'hfff));
        send_word(make_word(FUNC_DELAY, $urandom, 12'(DEPTH - MARGIN - 1)));
        // The unused func code only reports the mode.
        send_word(make_word(FUNC_UNUSED, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_WRITE, 32'h0bad_f00d, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
        send_word(make_word(FUNC_DELAY, $urandom, 12'd0));
        send_word(make_word(FUNC_WRITE, 32'h5a5a_5a5a, DELAY_W'($urandom)));
        send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));

        // Random segments: a delay request followed by a run of accesses.
        while (n_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      delay_pick = $urandom_range(0, 48);
            else if (pick < 85) delay_pick = $urandom_range(49, 600);
            else if (pick < 93) delay_pick = $urandom_range(DEPTH - MARGIN - 20, DEPTH - MARGIN - 1);
            else                delay_pick = $urandom_range(DEPTH - MARGIN, DEPTH - 1);
            send_word(make_word(FUNC_DELAY, rand_sample(), 12'(delay_pick)));
            n_items++;
            run_len = $urandom_range(8, 60);
            repeat (run_len) begin
                if (!squeeze_done && n_items >= SQUEEZE_AT) begin
                    squeeze_done = 1'b1;
                    squeeze_req  = 1'b1;
                end
                if (n_items >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_word(make_word(FUNC_UNUSED, $urandom, DELAY_W'($urandom)));
                end else begin
                    // A stray delay request breaks into the middle of a realignment.
                    if (pick < 5)       send_word(make_word(FUNC_DELAY, $urandom, DELAY_W'($urandom)));
                    else if (pick < 52) send_word(make_word(FUNC_WRITE, rand_sample(),
                                                            DELAY_W'($urandom)));
                    else                send_word(make_word(FUNC_READ, $urandom, DELAY_W'($urandom)));
                    n_items++;
                end
            end
        end
        i_in_valid <= 1'b0;

        // Drain the results still due, then wait out the drain margin and check again.
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending_words.size() != 0) begin
            $error("%0d result words never arrived", board.pending_words.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("audio_delay_line_realign_core regression: pass");
        end else begin
            $display("audio_delay_line_realign_core regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/adlr_pkg.sv
rtl/core/adlr_ram.sv
rtl/core/adlr_ctrl.sv
rtl/core/audio_delay_line_realign_core.sv
tb/sv/tb.sv
